FILE: rtl/mad_pkg.sv
package mad_pkg;

	localparam int MAX_ATTRS_DEF   = 16;
	localparam int MAX_CLASSES_DEF = 8;
	localparam int VALUE_SLOTS_DEF = 16;

	localparam int ATTR_W  = 4;
	localparam int CLASS_W = 3;
	localparam int VALUE_W = 4;
	localparam int NUM_W   = 32;
	localparam int COUNT_W = 16;
	localparam int NCLS_W  = 4;
	localparam int SUM_W   = 32;

	// divider: 48-bit dividend over 33-bit divisor, one quotient bit per cycle
	localparam int DIVD_W = 48;
	localparam int DIVS_W = 33;

	typedef enum logic [1:0] {
		MODE_LOAD_COUNT = 2'd0,
		MODE_LOAD_TOTAL = 2'd1,
		MODE_LOAD_ATTR  = 2'd2,
		MODE_COMPARE    = 2'd3
	} mode_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

FILE: rtl/mad_div.sv
module mad_div (
	input  logic              clk,
	input  logic              arst_n,
	input  mad_pkg::div_req_t req,
	output mad_pkg::div_rsp_t rsp
);
	import mad_pkg::*;

	localparam int CNT_W = $clog2(DIVD_W + 1);

	logic [DIVD_W-1:0] quo_q;
	logic [DIVS_W:0]   rem_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DIVS_W:0] shifted;
	logic [DIVS_W:0] diff;

	assign shifted = {rem_q[DIVS_W-1:0], quo_q[DIVD_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[DIVS_W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[DIVD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[DIVD_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

`ifndef SYNTHESIS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.start) else $error("divider restarted while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("done held");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("done while busy");
`endif
endmodule

FILE: rtl/mixed_attribute_dissimilarity_top.sv
// Mixed-attribute dissimilarity engine. Load transactions (mode 0..2) fill the
// class count, value total and attribute stores. A compare transaction on a
// numeric attribute runs one 48-step restoring division, none when the range is
// zero; a nominal compare runs two divisions for each of the n summed classes,
// all through one shared bit-serial divider that produces one quotient bit per
// cycle, and none when a value total or the class count is zero. The compare
// marked last also loads the output register. The class count store is a memory
// with one write port and one read port, read one entry per cycle. The result is
// held in the output register until taken; a further last compare waits until
// it has been taken. No clearing pass.
module mixed_attribute_dissimilarity_top #(
	parameter int MAX_ATTRS   = mad_pkg::MAX_ATTRS_DEF,
	parameter int MAX_CLASSES = mad_pkg::MAX_CLASSES_DEF,
	parameter int VALUE_SLOTS = mad_pkg::VALUE_SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [mad_pkg::NCLS_W-1:0]   num_classes,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   mode,
	input  logic [mad_pkg::ATTR_W-1:0]   attr_index,
	input  logic [mad_pkg::CLASS_W-1:0]  class_index,
	input  logic [mad_pkg::VALUE_W-1:0]  first_index,
	input  logic [mad_pkg::VALUE_W-1:0]  second_index,
	input  logic signed [mad_pkg::NUM_W-1:0] first_number,
	input  logic signed [mad_pkg::NUM_W-1:0] second_number,
	input  logic [mad_pkg::COUNT_W-1:0]  count,
	input  logic                         is_nominal,
	input  logic                         last,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mad_pkg::SUM_W-1:0]    dissimilarity,
	output logic                         zero_divisor
);
	import mad_pkg::*;

	localparam int AI_W   = (MAX_ATTRS > 1) ? $clog2(MAX_ATTRS) : 1;
	localparam int VI_W   = $clog2(VALUE_SLOTS);
	localparam int CC_DEP = MAX_ATTRS * MAX_CLASSES * VALUE_SLOTS;
	localparam int VT_DEP = MAX_ATTRS * VALUE_SLOTS;
	localparam int CC_W   = $clog2(CC_DEP);
	localparam int VT_W   = $clog2(VT_DEP);
	localparam int CN_W   = $clog2(MAX_CLASSES + 1);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_TOT    = 10'b0000000010,
		S_TOT2   = 10'b0000000100,
		S_CRD1   = 10'b0000001000,
		S_DIV1   = 10'b0000010000,
		S_CRD2   = 10'b0000100000,
		S_DIV2   = 10'b0001000000,
		S_NUMDIV = 10'b0010000000,
		S_ADD    = 10'b0100000000,
		S_OUT    = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [COUNT_W-1:0] cc_mem [CC_DEP];
	logic [COUNT_W-1:0] vt_mem [VT_DEP];
	logic [NUM_W-1:0]   amin_q [MAX_ATTRS];
	logic [NUM_W-1:0]   amax_q [MAX_ATTRS];
	logic               anom_q [MAX_ATTRS];

	logic [NCLS_W-1:0]  ncls_q;
	logic [SUM_W-1:0]   sum_q;
	logic               zero_q;
	logic [SUM_W-1:0]   res_q;
	logic               rzero_q;

	logic [AI_W-1:0]    a_q;
	logic [VI_W-1:0]    v1_q, v2_q;
	logic               last_q;
	logic [CN_W-1:0]    cls_q;
	logic [CN_W-1:0]    ncl_q;
	logic [COUNT_W-1:0] t1_q, t2_q;
	logic [COUNT_W-1:0] cc_rd_q;
	logic [COUNT_W-1:0] vt_rd_q;
	logic [DIVD_W-1:0]  r1_q;
	logic [DIVD_W:0]    term_q;

	div_req_t dreq;
	div_rsp_t drsp;

	mad_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic acc_in;
	logic attr_ok, cls_ok, v1_ok, v2_ok;
	logic [CC_W-1:0] cc_wa, cc_ra;
	logic [VT_W-1:0] vt_wa, vt_ra;
	logic [AI_W-1:0] a_in;
	logic [NUM_W:0]  x1e, x2e, mne, mxe, dxe, rge;
	logic [DIVD_W-1:0] r2;
	logic [DIVD_W:0]   tsum;
	logic [DIVD_W+1:0] ssum;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign acc_in    = in_valid && in_ready;

	assign attr_ok = (32'(attr_index) < MAX_ATTRS);
	assign cls_ok  = (32'(class_index) < MAX_CLASSES);
	assign v1_ok   = (32'(first_index) < VALUE_SLOTS);
	assign v2_ok   = (32'(second_index) < VALUE_SLOTS);
	assign a_in    = AI_W'(attr_index);

	assign cc_wa = CC_W'((32'(attr_index) * MAX_CLASSES + 32'(class_index)) * VALUE_SLOTS
		+ 32'(first_index));
	assign vt_wa = VT_W'(32'(attr_index) * VALUE_SLOTS + 32'(first_index));

	// first total is read straight off the input at the accepting edge
	always_comb begin
		cc_ra = CC_W'((32'(a_q) * MAX_CLASSES + 32'(cls_q)) * VALUE_SLOTS + 32'(v1_q));
		vt_ra = VT_W'(32'(a_q) * VALUE_SLOTS + 32'(v1_q));
		if (state_q == S_IDLE)
			vt_ra = vt_wa;
		if (state_q == S_TOT)
			vt_ra = VT_W'(32'(a_q) * VALUE_SLOTS + 32'(v2_q));
		if (state_q == S_DIV1)
			cc_ra = CC_W'((32'(a_q) * MAX_CLASSES + 32'(cls_q)) * VALUE_SLOTS + 32'(v2_q));
	end

	always_ff @(posedge clk) begin
		if (acc_in && mode == MODE_LOAD_COUNT && attr_ok && cls_ok && v1_ok)
			cc_mem[cc_wa] <= count;
		cc_rd_q <= cc_mem[cc_ra];
	end

	always_ff @(posedge clk) begin
		if (acc_in && mode == MODE_LOAD_TOTAL && attr_ok && v1_ok)
			vt_mem[vt_wa] <= count;
		vt_rd_q <= vt_mem[vt_ra];
	end

	always_ff @(posedge clk) begin
		if (acc_in && mode == MODE_LOAD_ATTR && attr_ok) begin
			amin_q[a_in] <= first_number;
			amax_q[a_in] <= second_number;
			anom_q[a_in] <= is_nominal;
		end
	end

	assign x1e = {first_number[NUM_W-1], first_number};
	assign x2e = {second_number[NUM_W-1], second_number};
	assign mne = {amin_q[a_in][NUM_W-1], amin_q[a_in]};
	assign mxe = {amax_q[a_in][NUM_W-1], amax_q[a_in]};
	assign dxe = ($signed(x1e) > $signed(x2e)) ? x1e - x2e : x2e - x1e;
	assign rge = ($signed(mxe) > $signed(mne)) ? mxe - mne : mne - mxe;

	assign r2   = drsp.quotient;
	assign tsum = term_q + ((r1_q > r2) ? {1'b0, r1_q - r2} : {1'b0, r2 - r1_q});
	assign ssum = (DIVD_W+2)'(sum_q) + (DIVD_W+2)'(term_q);

	always_comb begin
		dreq = '0;
		case (state_q)
			S_CRD1: begin
				dreq.start    = 1'b1;
				dreq.dividend = DIVD_W'({cc_rd_q, 16'h0});
				dreq.divisor  = DIVS_W'(t1_q);
			end
			S_CRD2: begin
				dreq.start    = 1'b1;
				dreq.dividend = DIVD_W'({cc_rd_q, 16'h0});
				dreq.divisor  = DIVS_W'(t2_q);
			end
			default: begin
				dreq.start    = (state_q == S_IDLE) && acc_in && mode == MODE_COMPARE
					&& attr_ok && !anom_q[a_in] && rge != '0;
				dreq.dividend = {dxe[NUM_W-1:0], 16'h0};
				dreq.divisor  = rge;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ncls_q  <= NCLS_W'(8);
			sum_q   <= '0;
			zero_q  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				ncls_q <= num_classes;
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (acc_in && mode == MODE_COMPARE) begin
						if (!attr_ok)
							state_q <= S_ADD;
						else if (anom_q[a_in])
							state_q <= (v1_ok && v2_ok) ? S_TOT : S_ADD;
						else if (rge == '0) begin
							zero_q  <= 1'b1;
							state_q <= S_ADD;
						end else
							state_q <= S_NUMDIV;
					end
				end
				S_TOT:  state_q <= S_TOT2;
				S_TOT2: begin
					if (vt_rd_q == '0 || t1_q == '0) begin
						zero_q  <= 1'b1;
						state_q <= S_ADD;
					end else if (ncl_q == '0)
						state_q <= S_ADD;
					else
						state_q <= S_CRD1;
				end
				S_CRD1: state_q <= S_DIV1;
				S_DIV1: if (drsp.done) state_q <= S_CRD2;
				S_CRD2: state_q <= S_DIV2;
				S_DIV2: begin
					if (drsp.done)
						state_q <= (cls_q + 1'b1 == ncl_q) ? S_ADD : S_TOT2;
				end
				S_NUMDIV: if (drsp.done) state_q <= S_ADD;
				S_ADD: begin
					if (ssum[DIVD_W+1:SUM_W] != '0)
						sum_q <= '1;
					else
						sum_q <= ssum[SUM_W-1:0];
					if (last_q)
						state_q <= S_OUT;
					else
						state_q <= S_IDLE;
				end
				S_OUT: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
						sum_q     <= '0;
						zero_q    <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// class loop re-enters S_TOT2 with totals known nonzero; keep t checks true
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				a_q    <= a_in;
				v1_q   <= VI_W'(first_index);
				v2_q   <= VI_W'(second_index);
				last_q <= last;
				cls_q  <= '0;
				term_q <= '0;
				ncl_q  <= (32'(ncls_q) > MAX_CLASSES) ? CN_W'(MAX_CLASSES) : CN_W'(ncls_q);
			end
			S_TOT:  t1_q <= vt_rd_q;
			S_TOT2: if (cls_q == '0) t2_q <= vt_rd_q;
			S_DIV1: if (drsp.done) r1_q <= drsp.quotient;
			S_DIV2: begin
				if (drsp.done) begin
					term_q <= tsum;
					cls_q  <= cls_q + 1'b1;
				end
			end
			S_NUMDIV: if (drsp.done) term_q <= {1'b0, drsp.quotient};
			S_OUT: begin
				if (!out_valid) begin
					res_q   <= sum_q;
					rzero_q <= zero_q;
				end
			end
			default: ;
		endcase
	end

	assign dissimilarity = res_q;
	assign zero_divisor  = rzero_q;

`ifndef SYNTHESIS
	a_busy_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready) else $error("accepted while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(dissimilarity) && out_valid)
		else $error("result changed while stalled");
	a_cls_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CRD1) |-> (cls_q < ncl_q)) else $error("class index past count");
`endif
endmodule
